// ----- sv/ame_pkg.sv -----
// ----------------------------------------------------------------------------
// Accumulator machine execute package
// Shared types, opcodes and sizes for the accumulator machine execute block.
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int MemWords = 256;
    localparam int AddrW    = $clog2(MemWords);
    localparam int CountW   = $clog2(MemWords + 1);

    typedef enum logic [4:0] {
        OP_LOAD   = 5'd0,
        OP_READ   = 5'd1,
        OP_CLEAR  = 5'd2,
        OP_AT     = 5'd3,
        OP_SET    = 5'd4,
        OP_INSERT = 5'd5,
        OP_ERASE  = 5'd6,
        OP_ADDC   = 5'd7,
        OP_SUBC   = 5'd8,
        OP_MULC   = 5'd9,
        OP_DIVC   = 5'd10,
        OP_ADDM   = 5'd11,
        OP_SUBM   = 5'd12,
        OP_MULM   = 5'd13,
        OP_DIVM   = 5'd14,
        OP_JREL   = 5'd15,
        OP_JZ     = 5'd16,
        OP_JNZ    = 5'd17,
        OP_NOOP   = 5'd18,
        OP_HALT   = 5'd19,
        OP_OUTPUT = 5'd20,
        OP_CHKMEM = 5'd21
    } t_op;

    typedef enum logic [1:0] {
        RS_RUN  = 2'd0,
        RS_HALT = 2'd1,
        RS_ERR  = 2'd2
    } t_run;

    typedef enum logic [2:0] {
        ARITH_ADD,
        ARITH_SUB,
        ARITH_MUL,
        ARITH_DIV
    } t_arith;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_RDDATA,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ARITH,
        S_ARWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   start;
        t_arith op;
        logic   busy;
        logic   done;
    } t_alu_ctl;

endpackage

// ----- sv/accumulator_machine_execute_top.sv -----
// ----------------------------------------------------------------------------
// Accumulator machine execute top
// Each transfer passes the read wait and read data states, with a shift read
// and a shift write state per moved word for insert and erase, and the ALU
// start and wait states for arithmetic, then the done state before the result
// strobe. A new transfer is taken in the strobe cycle, not before, so one
// instruction is finished before the next is accepted; busy is high from
// transfer until the strobe and the receiver cannot stall.
// Synchronous active-low reset clears the accumulator, the word count and the
// run state; memory contents are not cleared.
// ----------------------------------------------------------------------------
module accumulator_machine_execute_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         i_mode,
    input  logic signed [31:0] i_argument,
    input  logic signed [63:0] i_load_value,
    output logic               o_valid,
    output logic [1:0]         o_machine_state,
    output logic signed [31:0] o_jump_distance,
    output logic signed [63:0] o_acc_value,
    output logic               o_print_valid,
    output logic signed [63:0] o_read_value,
    output logic               o_read_valid
);
    import ame_pkg::*;

    logic [63:0] r_mem [MemWords];
    logic [63:0] r_rdata;
    logic        w_we;
    logic [AddrW-1:0] w_waddr, w_raddr;
    logic [63:0] w_wdata;

    t_state       r_state, n_state;
    t_run         r_run, n_run;
    logic [63:0]  r_acc, n_acc;
    logic [CountW-1:0] r_cnt, n_cnt;
    logic [CountW-1:0] r_k, n_k;
    logic [4:0]   r_mode;
    logic [31:0]  r_arg;
    logic [63:0]  r_load;
    logic         r_valid, n_valid;
    logic [1:0]   r_ms, n_ms;
    logic [31:0]  r_jump, n_jump;
    logic         r_pv, n_pv;
    logic [63:0]  r_rv, n_rv;
    logic         r_rvl, n_rvl;

    t_alu_ctl     w_alu_ctl, w_alu_stat;
    logic [63:0]  w_alu_res, w_alu_b;

    logic         w_neg, w_idx_ok, w_ins_ok;
    logic [AddrW-1:0] w_idx;

    assign w_neg    = r_arg[31];
    assign w_idx_ok = !w_neg && ({1'b0, r_arg} < 33'(r_cnt));
    assign w_ins_ok = !w_neg && ({1'b0, r_arg} <= 33'(r_cnt))
                      && (r_cnt < CountW'(MemWords));
    assign w_idx    = r_arg[AddrW-1:0];

    ame_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_alu_ctl),
        .i_a    (r_acc),
        .i_b    (w_alu_b),
        .o_stat (w_alu_stat),
        .o_res  (w_alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RDWAIT;
                end
            end
            S_RDWAIT: begin
                if (r_mode == OP_INSERT && r_run == RS_RUN && w_ins_ok
                    && r_cnt != CountW'(w_idx_ok ? r_arg[CountW-1:0] : r_cnt)) begin
                    n_state = S_SHIFT_RD;
                end else if (r_mode == OP_ERASE && r_run == RS_RUN && w_idx_ok
                             && 32'(r_cnt) > r_arg + 32'd1) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_RDDATA;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (r_mode == OP_INSERT) begin
                    n_state = (r_k - 1'b1 == CountW'(w_idx)) ? S_RDDATA : S_SHIFT_RD;
                end else begin
                    n_state = (r_k + 2'd2 >= r_cnt) ? S_RDDATA : S_SHIFT_RD;
                end
            end
            S_RDDATA: begin
                if (r_run == RS_RUN && (r_mode == OP_MULC || r_mode == OP_DIVC
                    || r_mode == OP_ADDC || r_mode == OP_SUBC
                    || (w_idx_ok && (r_mode == OP_ADDM || r_mode == OP_SUBM
                    || r_mode == OP_MULM || r_mode == OP_DIVM)))) begin
                    n_state = S_ARITH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ARITH:  n_state = (r_run == RS_RUN) ? S_ARWAIT : S_DONE;
            S_ARWAIT: n_state = w_alu_stat.done ? S_DONE : S_ARWAIT;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_run   = r_run;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_valid = 1'b0;
        n_ms    = r_ms;
        n_jump  = r_jump;
        n_pv    = r_pv;
        n_rv    = r_rv;
        n_rvl   = r_rvl;
        w_we    = 1'b0;
        w_waddr = w_idx;
        w_wdata = r_acc;
        w_raddr = w_idx;
        w_alu_ctl.start = 1'b0;
        w_alu_ctl.op    = ARITH_ADD;
        w_alu_ctl.busy  = 1'b0;
        w_alu_ctl.done  = 1'b0;
        w_alu_b = (r_mode == OP_ADDC || r_mode == OP_SUBC || r_mode == OP_MULC
                   || r_mode == OP_DIVC) ? {{32{r_arg[31]}}, r_arg} : r_rdata;
        unique case (r_state)
            S_RDWAIT: begin
                n_k = (r_mode == OP_INSERT) ? r_cnt : CountW'(w_idx);
                n_pv = 1'b0; n_rv = '0; n_rvl = 1'b0; n_jump = 32'd0;
            end
            S_SHIFT_RD: begin
                w_raddr = (r_mode == OP_INSERT) ? AddrW'(r_k - 1'b1) : AddrW'(r_k + 1'b1);
            end
            S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = AddrW'(r_k);
                w_wdata = r_rdata;
                n_k     = (r_mode == OP_INSERT) ? r_k - 1'b1 : r_k + 1'b1;
            end
            S_RDDATA: begin
                if (r_mode == OP_LOAD) begin
                    if (r_cnt < CountW'(MemWords)) begin
                        w_we    = 1'b1;
                        w_waddr = AddrW'(r_cnt);
                        w_wdata = r_load;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end else if (r_mode == OP_READ) begin
                    if (w_idx_ok) begin
                        n_rv = r_rdata; n_rvl = 1'b1;
                    end
                end else if (r_run == RS_RUN) begin
                    n_jump = 32'd1;
                    priority case (r_mode)
                        OP_CLEAR: n_acc = '0;
                        OP_AT: if (w_idx_ok) n_acc = r_rdata; else n_run = RS_ERR;
                        OP_SET: if (w_idx_ok) w_we = 1'b1; else n_run = RS_ERR;
                        OP_INSERT: begin
                            if (w_ins_ok) begin
                                w_we = 1'b1; n_cnt = r_cnt + 1'b1;
                            end else begin
                                n_run = RS_ERR;
                            end
                        end
                        OP_ERASE: if (w_idx_ok) n_cnt = r_cnt - 1'b1; else n_run = RS_ERR;
                        OP_ADDC, OP_SUBC, OP_MULC: ;
                        OP_DIVC: if (r_arg == 32'd0) n_run = RS_ERR;
                        OP_ADDM, OP_SUBM, OP_MULM: if (!w_idx_ok) n_run = RS_ERR;
                        OP_DIVM: if (!w_idx_ok || r_rdata == 64'd0) n_run = RS_ERR;
                        OP_JREL: n_jump = r_arg;
                        OP_JZ:   n_jump = (r_acc == 64'd0) ? r_arg : 32'd1;
                        OP_JNZ:  n_jump = (r_acc != 64'd0) ? r_arg : 32'd1;
                        OP_NOOP: ;
                        OP_HALT: n_run = RS_HALT;
                        OP_OUTPUT: n_pv = 1'b1;
                        OP_CHKMEM: if (!w_neg && 32'(r_cnt) < r_arg) n_run = RS_ERR;
                        default: n_run = RS_ERR;
                    endcase
                    if (n_run == RS_ERR || n_jump == 32'd0) begin
                        n_run = RS_ERR; n_jump = 32'd0;
                    end
                end
            end
            S_ARITH: begin
                if (r_run == RS_RUN) begin
                    w_alu_ctl.start = 1'b1;
                    w_alu_ctl.op = (r_mode == OP_ADDC || r_mode == OP_ADDM) ? ARITH_ADD :
                                   (r_mode == OP_SUBC || r_mode == OP_SUBM) ? ARITH_SUB :
                                   (r_mode == OP_MULC || r_mode == OP_MULM) ? ARITH_MUL :
                                   ARITH_DIV;
                end
            end
            S_ARWAIT: begin
                if (w_alu_stat.done) n_acc = w_alu_res;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_ms    = r_run;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= RS_RUN;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_k    <= n_k;
        r_ms   <= n_ms;
        r_jump <= n_jump;
        r_pv   <= n_pv;
        r_rv   <= n_rv;
        r_rvl  <= n_rvl;
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode;
            r_arg  <= i_argument;
            r_load <= i_load_value;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_machine_state = r_ms;
    assign o_jump_distance = r_jump;
    assign o_acc_value     = r_acc;
    assign o_print_valid   = r_pv;
    assign o_read_value    = r_rv;
    assign o_read_valid    = r_rvl;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CountW'(MemWords)) else $error("word count exceeds memory size");
    a_err_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_machine_state == RS_ERR |-> o_jump_distance == 32'd0)
        else $error("error result with nonzero jump");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_run) == RS_ERR && $past(i_rst_n) |-> r_run == RS_ERR)
        else $error("error state left without reset");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

endmodule

// ----- sv/ame_alu.sv -----
// ----------------------------------------------------------------------------
// Accumulator machine arithmetic unit
// Add and subtract registered directly from the start inputs, multiply by
// accumulating 16-bit partial products, signed divide by restoring division.
// ----------------------------------------------------------------------------
module ame_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ame_pkg::t_alu_ctl    i_ctl,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    output ame_pkg::t_alu_ctl    o_stat,
    output logic [63:0]          o_res
);
    import ame_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_arith      r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_b, n_b;
    logic        r_neg, n_neg;
    logic [64:0] w_trial;
    logic [31:0] w_pp;
    logic [1:0]  w_ai, w_bi;

    assign w_ai    = r_cnt[3:2];
    assign w_bi    = r_cnt[1:0];
    assign w_pp    = r_quo[16*w_ai +: 16] * r_b[16*w_bi +: 16];
    assign w_trial = {r_rem[62:0], r_quo[63]} - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_b    = r_b;
        n_neg  = r_neg;
        if (i_ctl.start) begin
            n_op   = i_ctl.op;
            n_cnt  = '0;
            unique case (i_ctl.op)
                ARITH_ADD: begin
                    n_acc  = i_a + i_b;
                    n_done = 1'b1;
                end
                ARITH_SUB: begin
                    n_acc  = i_a - i_b;
                    n_done = 1'b1;
                end
                ARITH_MUL: begin
                    n_busy = 1'b1;
                    n_acc  = '0;
                    n_quo  = i_a;
                    n_b    = i_b;
                end
                default: begin
                    n_busy = 1'b1;
                    n_quo  = i_a[63] ? (64'd0 - i_a) : i_a;
                    n_b    = i_b[63] ? (64'd0 - i_b) : i_b;
                    n_neg  = i_a[63] ^ i_b[63];
                    n_rem  = '0;
                end
            endcase
        end else if (r_busy) begin
            if (r_op == ARITH_MUL) begin
                if (32'(w_ai) * 32'd16 + 32'(w_bi) * 32'd16 < 32'd64) begin
                    n_acc = r_acc + (64'(w_pp) << (16 * (w_ai + w_bi)));
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd15) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end else begin
                if (!w_trial[64]) begin
                    n_rem = w_trial[63:0];
                end else begin
                    n_rem = {r_rem[62:0], r_quo[63]};
                end
                n_quo = {r_quo[62:0], ~w_trial[64]};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                    n_acc  = r_neg ? (64'd0 - {r_quo[62:0], ~w_trial[64]})
                                   : {r_quo[62:0], ~w_trial[64]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ARITH_ADD;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_b   <= n_b;
        r_neg <= n_neg;
    end

    assign o_stat.start = 1'b0;
    assign o_stat.op    = r_op;
    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_res        = r_acc;

endmodule

// ----- bench/tb_accumulator_machine_execute_top.sv -----
// ----------------------------------------------------------------------------
// Accumulator machine execute testbench
// Drives instruction transfers with random bursts and gaps, predicts every
// result with a behavioral model of the machine, and compares each strobed
// result field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_accumulator_machine_execute_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ame_pkg::*;

    typedef struct {
        logic [1:0]         run;
        logic signed [31:0] jump;
        logic signed [63:0] acc;
        logic               print;
        logic signed [63:0] rdata;
        logic               rvalid;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [4:0]         i_mode = '0;
    logic signed [31:0] i_argument = '0;
    logic signed [63:0] i_load_value = '0;
    logic               o_valid;
    logic [1:0]         o_machine_state;
    logic signed [31:0] o_jump_distance;
    logic signed [63:0] o_acc_value;
    logic               o_print_valid;
    logic signed [63:0] o_read_value;
    logic               o_read_valid;

    logic signed [63:0] m_acc;
    logic signed [63:0] m_mem [MemWords];
    int                 m_count;
    t_run               m_run;
    t_outcome           pending_q [$];
    int                 mismatches = 0;
    longint             cycles = 0;
    int                 burst_left = 0;

    accumulator_machine_execute_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [63:0] quot(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic t_outcome predict(logic [4:0] mode, logic signed [31:0] arg,
                                         logic signed [63:0] lval);
        t_outcome r;
        logic               err;
        logic               ok;
        logic signed [63:0] sarg;
        logic signed [63:0] w;
        int                 ix;
        err = 1'b0;
        sarg = arg;
        ix = arg;
        ok = !arg[31] && ix < m_count;
        r.jump = 0; r.print = 0; r.rdata = 0; r.rvalid = 0;
        if (mode == OP_LOAD) begin
            if (m_count < MemWords) begin
                m_mem[m_count] = lval;
                m_count++;
            end
        end else if (mode == OP_READ) begin
            if (ok) begin
                r.rdata = m_mem[ix];
                r.rvalid = 1;
            end
        end else if (m_run == RS_RUN) begin
            r.jump = 1;
            case (mode)
                OP_CLEAR: m_acc = 0;
                OP_AT: if (ok) m_acc = m_mem[ix]; else err = 1;
                OP_SET: if (ok) m_mem[ix] = m_acc; else err = 1;
                OP_INSERT: begin
                    if (!arg[31] && ix <= m_count && m_count < MemWords) begin
                        for (int k = m_count; k > ix; k--) m_mem[k] = m_mem[k-1];
                        m_mem[ix] = m_acc;
                        m_count++;
                    end else err = 1;
                end
                OP_ERASE: begin
                    if (ok) begin
                        for (int k = ix; k + 1 < m_count; k++) m_mem[k] = m_mem[k+1];
                        m_count--;
                    end else err = 1;
                end
                OP_ADDC: m_acc = m_acc + sarg;
                OP_SUBC: m_acc = m_acc - sarg;
                OP_MULC: m_acc = m_acc * sarg;
                OP_DIVC: if (sarg == 0) err = 1; else m_acc = quot(m_acc, sarg);
                OP_ADDM, OP_SUBM, OP_MULM, OP_DIVM: begin
                    if (!ok) err = 1;
                    else begin
                        w = m_mem[ix];
                        if (mode == OP_ADDM) m_acc = m_acc + w;
                        else if (mode == OP_SUBM) m_acc = m_acc - w;
                        else if (mode == OP_MULM) m_acc = m_acc * w;
                        else if (w == 0) err = 1;
                        else m_acc = quot(m_acc, w);
                    end
                end
                OP_JREL: r.jump = arg;
                OP_JZ: r.jump = (m_acc == 0) ? arg : 1;
                OP_JNZ: r.jump = (m_acc != 0) ? arg : 1;
                OP_NOOP: ;
                OP_HALT: m_run = RS_HALT;
                OP_OUTPUT: r.print = 1;
                OP_CHKMEM: if (!arg[31] && m_count < ix) err = 1;
                default: err = 1;
            endcase
            if (r.jump == 0) err = 1;
            if (err) begin
                m_run = RS_ERR;
                r.jump = 0;
            end
        end
        r.run = m_run;
        r.acc = m_acc;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = pending_q.pop_front();
                if (o_machine_state !== e.run || o_jump_distance !== e.jump ||
                    o_acc_value !== e.acc || o_print_valid !== e.print ||
                    o_read_value !== e.rdata || o_read_valid !== e.rvalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                                 e.run, e.jump, e.acc, e.print, e.rdata, e.rvalid,
                                 o_machine_state, o_jump_distance, o_acc_value,
                                 o_print_valid, o_read_value, o_read_valid);
                end
            end
        end
    end

    task automatic send(logic [4:0] mode, logic signed [31:0] arg,
                        logic signed [63:0] lval = 0);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        start <= 1'b1;
        i_mode <= mode;
        i_argument <= arg;
        i_load_value <= lval;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_q.insert(pending_q.size(), predict(mode, arg, lval));
        start <= 1'b0;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic restart_machine();
        // Only a stopped machine can be revived by reset; reset is single, so instead
        // the random part mostly sends loads once stopped and turns most halts into no-ops.
    endtask

    task automatic test_directed();
        send(OP_READ, 0);
        send(OP_LOAD, 0, 64'sh8000_0000_0000_0000);
        send(OP_LOAD, 0, 64'sh7FFF_FFFF_FFFF_FFFF);
        send(OP_LOAD, 0, 0);
        send(OP_LOAD, 0, -1);
        send(OP_READ, 1);
        send(OP_READ, 4);
        send(OP_READ, 32'sh8000_0000);
        send(OP_ADDC, 32'sh7FFF_FFFF);
        send(OP_SUBC, 32'sh8000_0000);
        send(OP_MULC, -7);
        send(OP_DIVC, -3);
        send(OP_AT, 0);
        send(OP_DIVC, -1);
        send(OP_ADDM, 1);
        send(OP_SUBM, 3);
        send(OP_MULM, 3);
        send(OP_DIVM, 3);
        send(OP_SET, 2);
        send(OP_INSERT, 4);
        send(OP_ERASE, 0);
        send(OP_JZ, 5);
        send(OP_JNZ, -2);
        send(OP_CLEAR, 0);
        send(OP_JREL, 32'sh8000_0000);
        send(OP_OUTPUT, 0);
        send(OP_CHKMEM, 4);
        send(OP_CHKMEM, -9);
        send(OP_NOOP, 0);
        send(OP_DIVM, 2);
        send(OP_AT, 1);
    endtask

    task automatic test_random();
        logic [4:0]         mode;
        logic signed [31:0] arg;
        logic signed [63:0] lval;
        int                 sel;
        for (int n = 0; n < 1150; n++) begin
            sel = $urandom_range(0, 99);
            lval = {$urandom, $urandom};
            if (sel < 25) begin
                mode = OP_LOAD;
                if ($urandom_range(0, 3) == 0) lval = $urandom_range(0, 3) - 1;
            end else if (sel < 97) mode = $urandom_range(OP_READ, OP_CHKMEM);
            else if (sel < 99) mode = $urandom_range(22, 31);
            else mode = $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0: arg = $urandom;
                1: arg = -$urandom_range(1, 3);
                2: arg = 0;
                3: arg = m_count;
                default: arg = (m_count > 0) ? $urandom_range(0, m_count - 1) : 0;
            endcase
            if (m_run != RS_RUN && mode > OP_READ && $urandom_range(0, 9) != 0) mode = OP_LOAD;
            if ((mode == OP_HALT) && $urandom_range(0, 9) != 0) mode = OP_NOOP;
            send(mode, arg, lval);
        end
    endtask

    initial begin
        m_acc = 0;
        m_count = 0;
        m_run = RS_RUN;
        foreach (m_mem[k]) m_mem[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
